### hw/rtl/spda_pkg.sv
// ----------------------------------------------------------------------------
// spda_pkg
// Shared types, register indexes and pipeline constants for the stereo pan
// and distance attenuator.
// ----------------------------------------------------------------------------
package spda_pkg;

    // pipeline geometry
    localparam int unsigned SQRT_STEPS = 21;
    localparam int unsigned DIV_STEPS  = 15;
    localparam int unsigned NUM_STAGES = 3 + SQRT_STEPS + 1 + DIV_STEPS + 3;

    // stage positions in the valid chain
    localparam int unsigned ST_GEO  = 0;
    localparam int unsigned ST_PROD = 1;
    localparam int unsigned ST_SUM  = 2;
    localparam int unsigned ST_DIV0 = ST_SUM + SQRT_STEPS + 1;
    localparam int unsigned ST_MIX  = ST_DIV0 + DIV_STEPS + 1;
    localparam int unsigned ST_GAIN = ST_MIX + 1;
    localparam int unsigned ST_FIN  = ST_GAIN + 1;

    // fixed-point constants
    localparam logic [15:0] ONE_Q14 = 16'd16384;
    localparam logic [38:0] ONE_Q28 = 39'd268435456;
    localparam logic [10:0] VOL_MAX = 11'd510;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_LISTENER_X  = 3'd0,
        REG_LISTENER_Y  = 3'd1,
        REG_LISTENER_Z  = 3'd2,
        REG_RIGHT_X     = 3'd3,
        REG_RIGHT_Y     = 3'd4,
        REG_RIGHT_Z     = 3'd5,
        REG_STEREO      = 3'd6,
        REG_VIEW_ENTITY = 3'd7
    } cfg_reg_t;

    // input item
    typedef struct packed {
        logic [15:0]        entity_id;
        logic [7:0]         master_volume;
        logic signed [19:0] source_x;
        logic signed [19:0] source_y;
        logic signed [19:0] source_z;
        logic [17:0]        distance_mult;
    } src_item_t;

    // result item
    typedef struct packed {
        logic [8:0] left_volume;
        logic [8:0] right_volume;
    } dst_item_t;

    // offset stage
    typedef struct packed {
        logic               view;
        logic [7:0]         master;
        logic [17:0]        mult;
        logic signed [20:0] dx;
        logic signed [20:0] dy;
        logic signed [20:0] dz;
    } geo_t;

    // product stage
    typedef struct packed {
        logic               view;
        logic [7:0]         master;
        logic [17:0]        mult;
        logic [41:0]        sxx;
        logic [41:0]        syy;
        logic [41:0]        szz;
        logic signed [36:0] px;
        logic signed [36:0] py;
        logic signed [36:0] pz;
    } prod_t;

    // square root stages
    typedef struct packed {
        logic               view;
        logic [7:0]         master;
        logic [17:0]        mult;
        logic [41:0]        n;
        logic [42:0]        r;
        logic signed [37:0] num;
    } sq_t;

    // divider stages
    typedef struct packed {
        logic        view;
        logic [7:0]  master;
        logic [38:0] len_mult;
        logic [20:0] len;
        logic        len0;
        logic        neg;
        logic        sat;
        logic [35:0] rem;
        logic [14:0] q;
    } div_t;

    // pan and attenuation stage
    typedef struct packed {
        logic        view;
        logic [7:0]  master;
        logic [15:0] ls;
        logic [15:0] rs;
        logic [28:0] atten;
    } mix_t;

    // master times pan stage
    typedef struct packed {
        logic        view;
        logic [7:0]  master;
        logic [23:0] pml;
        logic [23:0] pmr;
        logic [28:0] atten;
    } gain_t;

    // full gain product stage
    typedef struct packed {
        logic        view;
        logic [7:0]  master;
        logic [52:0] gl;
        logic [52:0] gr;
    } fin_t;

endpackage

### hw/rtl/stereo_pan_distance_attenuator.sv
// ----------------------------------------------------------------------------
// stereo_pan_distance_attenuator
// Turns one sound source into left and right volumes from its offset to the
// listener, its distance attenuation and a stereo pan.
// ----------------------------------------------------------------------------
// One item enters per cycle while src_stall is low; the pipeline holds the
// 21-step square root and the 15-step divider, each step its own pipeline
// stage. A two-entry output queue takes results, so the block keeps
// accepting items while a result waits; src_stall rises only when that
// queue is full. Configuration writes take effect at once and must be made
// while no item is in flight.
module stereo_pan_distance_attenuator (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  spda_pkg::src_item_t   src_item,
    output logic                  dst_valid,
    input  logic                  dst_stall,
    output spda_pkg::dst_item_t   dst_item,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [19:0]           cfg_data
);

    localparam int unsigned NST = spda_pkg::NUM_STAGES;
    localparam int unsigned NSQ = spda_pkg::SQRT_STEPS;
    localparam int unsigned NDV = spda_pkg::DIV_STEPS;

    // configuration registers
    logic signed [19:0] listener_x_reg, listener_y_reg, listener_z_reg;
    logic signed [15:0] right_x_reg, right_y_reg, right_z_reg;
    logic               stereo_reg;
    logic [15:0]        view_entity_reg;

    // pipeline registers
    logic [NST-1:0]     valid_reg;
    spda_pkg::geo_t     geo_reg, geo_next;
    spda_pkg::prod_t    prod_reg, prod_next;
    spda_pkg::sq_t      sq_reg [NSQ+1];
    spda_pkg::sq_t      sq_next [NSQ+1];
    spda_pkg::div_t     dv_reg [NDV+1];
    spda_pkg::div_t     dv_next [NDV+1];
    spda_pkg::mix_t     mix_reg, mix_next;
    spda_pkg::gain_t    gain_reg, gain_next;
    spda_pkg::fin_t     fin_reg, fin_next;

    // output queue
    spda_pkg::dst_item_t q_mem [2];
    logic                wr_ptr_reg, rd_ptr_reg;
    logic [1:0]          cnt_reg, cnt_next;
    spda_pkg::dst_item_t res;
    logic                en, push, pop;

    // pipeline advances while the queue has room
    assign en        = (cnt_reg != 2'd2);
    assign src_stall = !en;
    assign push      = en && valid_reg[spda_pkg::ST_FIN];
    assign pop       = dst_valid && !dst_stall;
    assign dst_valid = (cnt_reg != 2'd0);
    assign dst_item  = q_mem[rd_ptr_reg];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listener_x_reg  <= '0;
            listener_y_reg  <= '0;
            listener_z_reg  <= '0;
            right_x_reg     <= 16'sd16384;
            right_y_reg     <= '0;
            right_z_reg     <= '0;
            stereo_reg      <= 1'b1;
            view_entity_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (spda_pkg::cfg_reg_t'(cfg_index))
                spda_pkg::REG_LISTENER_X:  listener_x_reg  <= cfg_data;
                spda_pkg::REG_LISTENER_Y:  listener_y_reg  <= cfg_data;
                spda_pkg::REG_LISTENER_Z:  listener_z_reg  <= cfg_data;
                spda_pkg::REG_RIGHT_X:     right_x_reg     <= cfg_data[15:0];
                spda_pkg::REG_RIGHT_Y:     right_y_reg     <= cfg_data[15:0];
                spda_pkg::REG_RIGHT_Z:     right_z_reg     <= cfg_data[15:0];
                spda_pkg::REG_STEREO:      stereo_reg      <= cfg_data[0];
                spda_pkg::REG_VIEW_ENTITY: view_entity_reg <= cfg_data[15:0];
                default:                   ;
            endcase
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NST-2:0], src_valid};
        end
    end

    // offset from the listener
    always_comb
    begin
        geo_next.view   = (src_item.entity_id == view_entity_reg);
        geo_next.master = src_item.master_volume;
        geo_next.mult   = src_item.distance_mult;
        geo_next.dx     = 21'({src_item.source_x[19], src_item.source_x})
                          - 21'({listener_x_reg[19], listener_x_reg});
        geo_next.dy     = 21'({src_item.source_y[19], src_item.source_y})
                          - 21'({listener_y_reg[19], listener_y_reg});
        geo_next.dz     = 21'({src_item.source_z[19], src_item.source_z})
                          - 21'({listener_z_reg[19], listener_z_reg});
    end

    // squares and right vector products
    logic signed [41:0] sq_x, sq_y, sq_z;
    always_comb
    begin
        sq_x             = geo_reg.dx * geo_reg.dx;
        sq_y             = geo_reg.dy * geo_reg.dy;
        sq_z             = geo_reg.dz * geo_reg.dz;
        prod_next.view   = geo_reg.view;
        prod_next.master = geo_reg.master;
        prod_next.mult   = geo_reg.mult;
        prod_next.sxx    = $unsigned(sq_x);
        prod_next.syy    = $unsigned(sq_y);
        prod_next.szz    = $unsigned(sq_z);
        prod_next.px     = right_x_reg * geo_reg.dx;
        prod_next.py     = right_y_reg * geo_reg.dy;
        prod_next.pz     = right_z_reg * geo_reg.dz;
    end

    // sums feed the square root
    always_comb
    begin
        sq_next[0].view   = prod_reg.view;
        sq_next[0].master = prod_reg.master;
        sq_next[0].mult   = prod_reg.mult;
        sq_next[0].n      = prod_reg.sxx + prod_reg.syy + prod_reg.szz;
        sq_next[0].r      = '0;
        sq_next[0].num    = prod_reg.px + prod_reg.py + prod_reg.pz;
    end

    // square root, one result bit per stage
    for (genvar j = 0; j < NSQ; j++)
    begin : g_sqrt
        localparam logic [42:0] BIT = 43'(1) << (2 * (NSQ - 1 - j));
        logic [42:0] trial;
        always_comb
        begin
            trial      = sq_reg[j].r + BIT;
            sq_next[j+1] = sq_reg[j];
            if ({1'b0, sq_reg[j].n} >= trial)
            begin
                sq_next[j+1].n = 42'({1'b0, sq_reg[j].n} - trial);
                sq_next[j+1].r = (sq_reg[j].r >> 1) + BIT;
            end
            else
            begin
                sq_next[j+1].r = sq_reg[j].r >> 1;
            end
        end
    end

    // divider setup, range check and distance product
    logic [20:0]        len;
    logic signed [37:0] num_neg;
    logic [37:0]        abs_num;
    always_comb
    begin
        len                   = sq_reg[NSQ].r[20:0];
        num_neg               = -sq_reg[NSQ].num;
        abs_num               = sq_reg[NSQ].num[37] ? $unsigned(num_neg)
                                                    : $unsigned(sq_reg[NSQ].num);
        dv_next[0].view       = sq_reg[NSQ].view;
        dv_next[0].master     = sq_reg[NSQ].master;
        dv_next[0].len_mult   = 39'(len) * 39'(sq_reg[NSQ].mult);
        dv_next[0].len        = len;
        dv_next[0].len0       = (len == 21'd0);
        dv_next[0].neg        = sq_reg[NSQ].num[37];
        dv_next[0].sat        = abs_num >= (38'(len) << NDV);
        dv_next[0].rem        = abs_num[35:0];
        dv_next[0].q          = '0;
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < NDV; j++)
    begin : g_div
        localparam int unsigned K = NDV - 1 - j;
        logic [36:0] dvs;
        always_comb
        begin
            dvs          = 37'(dv_reg[j].len) << K;
            dv_next[j+1] = dv_reg[j];
            if ({1'b0, dv_reg[j].rem} >= dvs)
            begin
                dv_next[j+1].rem  = 36'({1'b0, dv_reg[j].rem} - dvs);
                dv_next[j+1].q[K] = 1'b1;
            end
        end
    end

    // pan factors and attenuation
    logic [14:0] qmag;
    always_comb
    begin
        if (dv_reg[NDV].len0)
            qmag = '0;
        else if (dv_reg[NDV].sat || (dv_reg[NDV].q > 15'd16384))
            qmag = 15'd16384;
        else
            qmag = dv_reg[NDV].q;
        mix_next.view   = dv_reg[NDV].view;
        mix_next.master = dv_reg[NDV].master;
        if (!stereo_reg)
        begin
            mix_next.ls = spda_pkg::ONE_Q14;
            mix_next.rs = spda_pkg::ONE_Q14;
        end
        else if (dv_reg[NDV].neg)
        begin
            mix_next.ls = spda_pkg::ONE_Q14 + 16'(qmag);
            mix_next.rs = spda_pkg::ONE_Q14 - 16'(qmag);
        end
        else
        begin
            mix_next.ls = spda_pkg::ONE_Q14 - 16'(qmag);
            mix_next.rs = spda_pkg::ONE_Q14 + 16'(qmag);
        end
        if (dv_reg[NDV].len_mult < spda_pkg::ONE_Q28)
            mix_next.atten = 29'(spda_pkg::ONE_Q28 - dv_reg[NDV].len_mult);
        else
            mix_next.atten = '0;
    end

    // master times pan
    always_comb
    begin
        gain_next.view   = mix_reg.view;
        gain_next.master = mix_reg.master;
        gain_next.pml    = 24'(mix_reg.master) * 24'(mix_reg.ls);
        gain_next.pmr    = 24'(mix_reg.master) * 24'(mix_reg.rs);
        gain_next.atten  = mix_reg.atten;
    end

    // times attenuation
    always_comb
    begin
        fin_next.view   = gain_reg.view;
        fin_next.master = gain_reg.master;
        fin_next.gl     = 53'(gain_reg.pml) * 53'(gain_reg.atten);
        fin_next.gr     = 53'(gain_reg.pmr) * 53'(gain_reg.atten);
    end

    // scale, clamp and view entity select
    logic [10:0] vl, vr;
    always_comb
    begin
        vl = fin_reg.gl[52:42];
        vr = fin_reg.gr[52:42];
        if (fin_reg.view)
        begin
            res.left_volume  = {1'b0, fin_reg.master};
            res.right_volume = {1'b0, fin_reg.master};
        end
        else
        begin
            res.left_volume  = (vl > spda_pkg::VOL_MAX) ? spda_pkg::VOL_MAX[8:0] : vl[8:0];
            res.right_volume = (vr > spda_pkg::VOL_MAX) ? spda_pkg::VOL_MAX[8:0] : vr[8:0];
        end
    end

    // pipeline data registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_reg  <= geo_next;
            prod_reg <= prod_next;
            for (int i = 0; i <= NSQ; i++)
            begin
                sq_reg[i] <= sq_next[i];
            end
            for (int i = 0; i <= NDV; i++)
            begin
                dv_reg[i] <= dv_next[i];
            end
            mix_reg  <= mix_next;
            gain_reg <= gain_next;
            fin_reg  <= fin_next;
        end
    end

    // output queue count
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    // output queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= res;
    end

`ifndef ASSERT_OFF
    // volumes never pass the clamp
    a_vol_range: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> (dst_item.left_volume <= 9'd510)
                   && (dst_item.right_volume <= 9'd510))
        else $error("volume above clamp");

    // an empty output queue never stalls the input
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !dst_valid |-> !src_stall)
        else $error("input stalled with empty output queue");

    // an accepted item occupies the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (src_valid && !src_stall) |=> valid_reg[spda_pkg::ST_GEO])
        else $error("accepted item lost at entry");
`endif

endmodule
